FILE: rtl/core/rcptm_pkg.sv
// Shared types and constants for the RC pulse capture and tank mixer.
package rcptm_pkg;

  localparam int DUTY_MAX_DEF  = 255;
  localparam int TIME_BITS_DEF = 32;

  localparam int WIDTH_W  = 16;
  localparam int CENTER_W = 10;
  localparam int GAIN_W   = 4;
  localparam int TERM_W   = WIDTH_W + GAIN_W + 2;
  localparam int CMD_W    = TERM_W + 1;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CENTER_W;

  localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(200);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_GAIN   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [GAIN_W-1:0]   gain;
  } mix_cfg_t;

endpackage

FILE: rtl/core/rc_pulse_capture_tank_mixer_top.sv
// Top level of the RC pulse capture and differential-drive mixer.
//
// Every input item is one timer tick carrying the sampled levels of the two
// pulse pins (in_tdata bit 0 vertical, bit 1 horizontal). A free-running tick
// counter advances once per accepted item and timestamps rising edges; a
// falling edge stores the elapsed ticks as that channel's pulse width,
// saturated at 65535. Each channel runs in its own lane, which scales the
// width minus the center by the gain; a merging stage forms the right (sum)
// and left (difference) motor commands as reverse flag plus saturated duty.
//
// Every item yields exactly one result item, which passes the width and term
// registers into the output register. The block takes one item per cycle;
// the three stages advance together and only stop when the output register
// holds a result the receiver has not taken, so in_tready follows out_tready
// while a result is pending.
// The configuration channel is always ready; writes are expected only while
// no items are in flight. Reset clears the tick counter, rise times, widths
// and previous levels, loads center 200 and gain 5, and empties the pipeline.
module rc_pulse_capture_tank_mixer_top #(
  parameter int DUTY_MAX  = rcptm_pkg::DUTY_MAX_DEF,
  parameter int TIME_BITS = rcptm_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [0] vertical_level, [1] horizontal_level, [7:2] zero
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  // out_tdata: [0] right_reverse, [8:1] right_duty, [9] left_reverse,
  // [17:10] left_duty, [23:18] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcptm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcptm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rcptm_pkg::*;

  logic [CENTER_W-1:0]  center_r, center_nxt;
  logic [GAIN_W-1:0]    gain_r, gain_nxt;
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic                 v1_r, v1_nxt, v2_r, v2_nxt;
  logic                 advance, in_accept;
  mix_cfg_t             cfg;
  logic signed [TERM_W-1:0] term_a, term_b;
  logic                 right_reverse, left_reverse;
  logic [DUTY_W-1:0]    right_duty, left_duty;

  // The whole pipeline moves whenever the output register is free or drained.
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    center_nxt = center_r;
    gain_nxt   = gain_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER: center_nxt = cfg_data[CENTER_W-1:0];
        CFG_GAIN:   gain_nxt   = cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
    tick_nxt = in_accept ? tick_r + 1'b1 : tick_r;
    v1_nxt   = advance ? in_tvalid : v1_r;
    v2_nxt   = advance ? v1_r : v2_r;
    cfg.center = center_r;
    cfg.gain   = gain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      gain_r   <= GAIN_RST;
      tick_r   <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      center_r <= center_nxt;
      gain_r   <= gain_nxt;
      tick_r   <= tick_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
    end
  end

  rcptm_lane #(.TIME_BITS(TIME_BITS)) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .advance (advance),
    .level   (in_tdata[0]),
    .now     (tick_r),
    .cfg     (cfg),
    .term    (term_a)
  );

  rcptm_lane #(.TIME_BITS(TIME_BITS)) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .advance (advance),
    .level   (in_tdata[1]),
    .now     (tick_r),
    .cfg     (cfg),
    .term    (term_b)
  );

  rcptm_merge #(.DUTY_MAX(DUTY_MAX)) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .valid_in      (v2_r),
    .term_a        (term_a),
    .term_b        (term_b),
    .valid         (out_tvalid),
    .right_reverse (right_reverse),
    .right_duty    (right_duty),
    .left_reverse  (left_reverse),
    .left_duty     (left_duty)
  );

  assign out_tdata = {6'b0, left_duty, left_reverse, right_duty, right_reverse};

  // A stalled, full output register must hold back new items.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");

  // The tick counter steps by exactly one per accepted item.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (tick_r == $past(tick_r) + 1'b1))
    else $error("tick counter did not advance on accept");

  // An item in the term stage reaches the output register when the pipeline moves.
  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && advance) |=> out_tvalid)
    else $error("result lost between term stage and output");

  // Without any item in flight no result can appear.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!v2_r && advance) |=> !out_tvalid)
    else $error("result produced without an item");

endmodule

FILE: rtl/core/rcptm_lane.sv
// One pulse channel: edge capture, width measurement and centered scaling.
module rcptm_lane #(
  parameter int TIME_BITS = rcptm_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                advance,
  input  logic                                level,
  input  logic [TIME_BITS-1:0]                now,
  input  rcptm_pkg::mix_cfg_t                 cfg,
  output logic signed [rcptm_pkg::TERM_W-1:0] term
);
  import rcptm_pkg::*;

  logic                 prev_r, prev_nxt;
  logic [TIME_BITS-1:0] rise_r, rise_nxt;
  logic [WIDTH_W-1:0]   width_r, width_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;

  logic [TIME_BITS-1:0]         elapsed;
  logic [TIME_BITS+WIDTH_W-1:0] elapsed_ext;
  logic                         elapsed_sat;
  logic signed [WIDTH_W:0]      centered;

  always_comb begin
    elapsed     = now - rise_r;
    elapsed_ext = {{WIDTH_W{1'b0}}, elapsed};
    elapsed_sat = |elapsed_ext[TIME_BITS+WIDTH_W-1:WIDTH_W];
    prev_nxt  = prev_r;
    rise_nxt  = rise_r;
    width_nxt = width_r;
    if (accept) begin
      prev_nxt = level;
      if (level && !prev_r) begin
        rise_nxt = now;
      end else if (!level && prev_r) begin
        width_nxt = elapsed_sat ? {WIDTH_W{1'b1}} : elapsed_ext[WIDTH_W-1:0];
      end
    end
    // The term stage reads the width left by the item one stage ahead.
    centered = $signed({1'b0, width_r}) - $signed({{(WIDTH_W-CENTER_W+1){1'b0}}, cfg.center});
    term_nxt = TERM_W'(centered) * TERM_W'($signed({1'b0, cfg.gain}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      rise_r  <= '0;
      width_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      rise_r  <= rise_nxt;
      width_r <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

FILE: rtl/core/rcptm_merge.sv
// Merging stage: sum and difference of the lane terms, sign and saturated duty.
module rcptm_merge #(
  parameter int DUTY_MAX = rcptm_pkg::DUTY_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                valid_in,
  input  logic signed [rcptm_pkg::TERM_W-1:0] term_a,
  input  logic signed [rcptm_pkg::TERM_W-1:0] term_b,
  output logic                                valid,
  output logic                                right_reverse,
  output logic [rcptm_pkg::DUTY_W-1:0]        right_duty,
  output logic                                left_reverse,
  output logic [rcptm_pkg::DUTY_W-1:0]        left_duty
);
  import rcptm_pkg::*;

  localparam logic [CMD_W-1:0] DUTY_CAP = CMD_W'(DUTY_MAX);

  logic signed [CMD_W-1:0] sum_cmd, dif_cmd;
  logic [CMD_W-1:0]        sum_mag, dif_mag, sum_sat, dif_sat;

  logic              valid_r, valid_nxt;
  logic              rrev_r, rrev_nxt, lrev_r, lrev_nxt;
  logic [DUTY_W-1:0] rduty_r, rduty_nxt, lduty_r, lduty_nxt;

  always_comb begin
    sum_cmd = CMD_W'(term_a) + CMD_W'(term_b);
    dif_cmd = CMD_W'(term_a) - CMD_W'(term_b);
    sum_mag = sum_cmd[CMD_W-1] ? CMD_W'(-sum_cmd) : CMD_W'(sum_cmd);
    dif_mag = dif_cmd[CMD_W-1] ? CMD_W'(-dif_cmd) : CMD_W'(dif_cmd);
    sum_sat = (sum_mag > DUTY_CAP) ? DUTY_CAP : sum_mag;
    dif_sat = (dif_mag > DUTY_CAP) ? DUTY_CAP : dif_mag;
    valid_nxt = advance ? valid_in : valid_r;
    rrev_nxt  = sum_cmd[CMD_W-1];
    lrev_nxt  = dif_cmd[CMD_W-1];
    rduty_nxt = sum_sat[DUTY_W-1:0];
    lduty_nxt = dif_sat[DUTY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rrev_r  <= rrev_nxt;
      lrev_r  <= lrev_nxt;
      rduty_r <= rduty_nxt;
      lduty_r <= lduty_nxt;
    end
  end

  assign valid         = valid_r;
  assign right_reverse = rrev_r;
  assign right_duty    = rduty_r;
  assign left_reverse  = lrev_r;
  assign left_duty     = lduty_r;

endmodule
